FILE: hdl/gte_pkg.sv
// Shared constants, types and tables for the geodetic to ECEF converter.
package gte_pkg;

  localparam int LAT_W = 31;
  localparam int LON_W = 32;
  localparam int ALT_W = 28;
  localparam int XYZ_W = 34;

  localparam int ANG_W  = 32;  // Q30 radians
  localparam int TRIG_W = 32;  // Q30 sin/cos, [-1, 1] inclusive of both ends
  localparam int CW     = 34;  // CORDIC x/y
  localparam int ZW     = 33;  // CORDIC residual angle

  localparam int D_W       = 41;  // 1 - e2 sin^2, Q40
  localparam int ROOT_W    = 31;
  localparam int NQ_W      = 34;
  localparam int SQ_STEPS  = 31;
  localparam int DIV_STEPS = 34;
  localparam int RAD_LAT   = SQ_STEPS + DIV_STEPS;

  localparam int DEF_CORDIC_STAGES = 24;
  localparam int MAX_STAGES        = 32;

  localparam logic signed [LAT_W-1:0] LAT_LIM = 31'sd754974720;
  localparam logic signed [LON_W-1:0] LON_LIM = 32'sd1509949440;
  localparam logic signed [LON_W-1:0] QTURN   = 32'sd754974720;
  localparam logic signed [LON_W-1:0] HTURN   = 32'sd1509949440;
  localparam logic signed [ALT_W-1:0] ALT_LIM = 28'sd100000000;

  localparam logic [32:0]          RAD_K    = 33'd4797524517;  // pi/180 * 2^38
  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [CW-1:0] Q_ONE    = 34'sd1073741824;
  localparam logic [28:0]          ECC2_Q36 = 29'd460034290;
  localparam logic [63:0]          SEMI_Q30 = 64'd6378137000 << 30;

  typedef struct packed {
    logic signed [ALT_W-1:0]  alt;
    logic signed [TRIG_W-1:0] clat;
    logic signed [TRIG_W-1:0] slat;
    logic signed [TRIG_W-1:0] clon;
    logic signed [TRIG_W-1:0] slon;
  } side_t;

  function automatic logic [29:0] atan_q30(input int i);
    logic [29:0] a;
    case (i)
      0:  a = 30'h3243F6A8;
      1:  a = 30'h1DAC6705;
      2:  a = 30'h0FADBAFC;
      3:  a = 30'h07F56EA6;
      4:  a = 30'h03FEAB76;
      5:  a = 30'h01FFD55B;
      6:  a = 30'h00FFFAAA;
      7:  a = 30'h007FFF55;
      8:  a = 30'h003FFFEA;
      9:  a = 30'h001FFFFD;
      10: a = 30'h000FFFFF;
      11: a = 30'h0007FFFF;
      12: a = 30'h0003FFFF;
      13: a = 30'h0001FFFF;
      14: a = 30'h0000FFFF;
      15: a = 30'h00007FFF;
      16: a = 30'h00003FFF;
      17: a = 30'h00001FFF;
      18: a = 30'h00000FFF;
      19: a = 30'h000007FF;
      20: a = 30'h000003FF;
      21: a = 30'h000001FF;
      22: a = 30'h000000FF;
      23: a = 30'h0000007F;
      24: a = 30'h0000003F;
      25: a = 30'h0000001F;
      26: a = 30'h0000000F;
      27: a = 30'h00000008;
      28: a = 30'h00000004;
      29: a = 30'h00000002;
      30: a = 30'h00000001;
      default: a = 30'h00000000;
    endcase
    return a;
  endfunction

endpackage

FILE: hdl/gte_ifs.sv
// Request channel interfaces for geodetic input and ECEF results.
interface gte_in_if;
  import gte_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [LAT_W-1:0] latitude;
  logic signed [LON_W-1:0] longitude;
  logic signed [ALT_W-1:0] altitude;
  modport source (output valid, latitude, longitude, altitude, input ready);
  modport sink (input valid, latitude, longitude, altitude, output ready);
endinterface

interface gte_out_if;
  import gte_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [XYZ_W-1:0] ecef_x;
  logic signed [XYZ_W-1:0] ecef_y;
  logic signed [XYZ_W-1:0] ecef_z;
  modport source (output valid, ecef_x, ecef_y, ecef_z, input ready);
  modport sink (input valid, ecef_x, ecef_y, ecef_z, output ready);
endinterface

FILE: hdl/geodetic_to_ecef_convert.sv
// Throughput: one request per cycle; a stalled output freezes the whole pipe.
// Depth is set by the CORDIC stages, 31-step square root and 34-step divide.
// Reset (synchronous, active low) clears only the valid bits of the pipe.
module geodetic_to_ecef_convert #(
  parameter int CORDIC_STAGES = gte_pkg::DEF_CORDIC_STAGES
) (
  input logic       clk,
  input logic       rst_n,
  gte_in_if.sink    in_ch,
  gte_out_if.source out_ch
);
  import gte_pkg::*;

  localparam int NST = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
  localparam int LAT = NST + 10 + RAD_LAT;

  function automatic logic signed [ANG_W-1:0] to_rad(input logic signed [LON_W-1:0] u);
    logic        neg;
    logic [31:0] mag;
    logic [62:0] prod;
    logic [31:0] r;
    neg  = u[LON_W-1];
    mag  = neg ? 32'(-u) : 32'(u);
    prod = 63'(mag[29:0]) * 63'(RAD_K) + (63'(1) << 30);
    r    = prod[62:31];
    return neg ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [38:0] rnd30(input logic signed [68:0] v);
    logic signed [68:0] t;
    t = v + 69'sd536870912;
    return 39'(t >>> 30);
  endfunction

  logic en;
  logic [LAT-1:0] vld_r;

  assign en          = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[LAT-2:0], in_ch.valid};
  end

  // input clamp and longitude fold into +-90 degrees
  logic signed [LAT_W-1:0] lat_c;
  logic signed [LON_W-1:0] lon_c, lon_a;
  logic signed [ALT_W-1:0] alt_c;
  logic                    flip;

  always_comb begin
    if (in_ch.latitude > LAT_LIM) lat_c = LAT_LIM;
    else if (in_ch.latitude < -LAT_LIM) lat_c = -LAT_LIM;
    else lat_c = in_ch.latitude;
    if (in_ch.longitude > LON_LIM) lon_c = LON_LIM;
    else if (in_ch.longitude < -LON_LIM) lon_c = -LON_LIM;
    else lon_c = in_ch.longitude;
    if (in_ch.altitude > ALT_LIM) alt_c = ALT_LIM;
    else if (in_ch.altitude < -ALT_LIM) alt_c = -ALT_LIM;
    else alt_c = in_ch.altitude;
    flip  = 1'b0;
    lon_a = lon_c;
    if (lon_c > QTURN) begin
      lon_a = lon_c - HTURN;
      flip  = 1'b1;
    end else if (lon_c < -QTURN) begin
      lon_a = lon_c + HTURN;
      flip  = 1'b1;
    end
  end

  logic signed [LON_W-1:0] lat0_r, lon0_r;
  logic signed [ALT_W-1:0] alt0_r, alt1_r;
  logic                    flip0_r, flip1_r;
  logic signed [ANG_W-1:0] latr_r, lonr_r;

  always_ff @(posedge clk) begin
    if (en) begin
      lat0_r  <= LON_W'(lat_c);
      lon0_r  <= lon_a;
      alt0_r  <= alt_c;
      flip0_r <= flip;
      latr_r  <= to_rad(lat0_r);
      lonr_r  <= to_rad(lon0_r);
      alt1_r  <= alt0_r;
      flip1_r <= flip0_r;
    end
  end

  logic signed [TRIG_W-1:0] clat_w, slat_w, clon_w, slon_w;

  gte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_lat (
    .clk(clk), .en(en), .angle_i(latr_r), .cos_o(clat_w), .sin_o(slat_w)
  );

  gte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_lon (
    .clk(clk), .en(en), .angle_i(lonr_r), .cos_o(clon_w), .sin_o(slon_w)
  );

  logic signed [ALT_W-1:0] altc_r  [NST];
  logic                    flipc_r [NST];

  for (genvar g = 0; g < NST; g++) begin : gen_cdly
    always_ff @(posedge clk) begin
      if (en) begin
        altc_r[g]  <= (g == 0) ? alt1_r : altc_r[(g == 0) ? 0 : g - 1];
        flipc_r[g] <= (g == 0) ? flip1_r : flipc_r[(g == 0) ? 0 : g - 1];
      end
    end
  end

  side_t       c1_r, c2_r, c3_r;
  logic [30:0] s2_r;
  logic [D_W-1:0] d_r;
  logic [61:0] sq;
  logic [59:0] es;

  assign sq = 62'(c1_r.slat * c1_r.slat) + (62'(1) << 29);
  assign es = 60'(s2_r) * 60'(ECC2_Q36);

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r.alt  <= altc_r[NST-1];
      c1_r.clat <= clat_w;
      c1_r.slat <= slat_w;
      c1_r.clon <= flipc_r[NST-1] ? -clon_w : clon_w;
      c1_r.slon <= flipc_r[NST-1] ? -slon_w : slon_w;
      s2_r      <= sq[60:30];
      c2_r      <= c1_r;
      d_r       <= (D_W'(1) << 40) - D_W'(es >> 26);
      c3_r      <= c2_r;
    end
  end

  logic [NQ_W-1:0] n_w;

  gte_nrad u_nrad (.clk(clk), .en(en), .d_i(d_r), .n_o(n_w));

  side_t side_d_r [RAD_LAT];

  for (genvar g = 0; g < RAD_LAT; g++) begin : gen_sdly
    always_ff @(posedge clk) begin
      if (en) side_d_r[g] <= (g == 0) ? c3_r : side_d_r[(g == 0) ? 0 : g - 1];
    end
  end

  side_t               sa_r, sb_r, sc_r;
  logic [NQ_W-1:0]     na_r;
  logic signed [35:0]  nh_r, mh_r, p_r;
  logic [62:0]         ne_r;
  logic [26:0]         rq;
  logic signed [66:0]  pp_r, zp_r, xp_r, yp_r;
  logic signed [XYZ_W-1:0] zd_r, ox_r, oy_r, oz_r;

  assign rq = 27'((ne_r + (63'(1) << 35)) >> 36);

  always_ff @(posedge clk) begin
    if (en) begin
      // stage A
      sa_r <= side_d_r[RAD_LAT-1];
      na_r <= n_w;
      nh_r <= $signed({2'b00, n_w}) + 36'(side_d_r[RAD_LAT-1].alt);
      ne_r <= 63'(n_w) * 63'(ECC2_Q36);
      // stage B
      sb_r <= sa_r;
      mh_r <= $signed({2'b00, na_r}) - $signed(36'(rq)) + 36'(sa_r.alt);
      pp_r <= nh_r * sa_r.clat;
      // stage C
      sc_r <= sb_r;
      p_r  <= 36'(rnd30(69'(pp_r)));
      zp_r <= mh_r * sb_r.slat;
      // stage D
      xp_r <= p_r * sc_r.clon;
      yp_r <= p_r * sc_r.slon;
      zd_r <= XYZ_W'(rnd30(69'(zp_r)));
      // output
      ox_r <= XYZ_W'(rnd30(69'(xp_r)));
      oy_r <= XYZ_W'(rnd30(69'(yp_r)));
      oz_r <= zd_r;
    end
  end

  assign out_ch.valid  = vld_r[LAT-1];
  assign out_ch.ecef_x = ox_r;
  assign out_ch.ecef_y = oy_r;
  assign out_ch.ecef_z = oz_r;

`ifndef NO_ASSERTIONS
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> vld_r == '0)
    else $error("pipe valid bits not cleared by reset");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipe valid bits moved during stall");
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> vld_r[0])
    else $error("accepted request did not enter the pipe");
`endif

endmodule

FILE: hdl/gte_cordic.sv
// Pipelined rotation-mode CORDIC producing Q30 sine and cosine.
module gte_cordic #(
  parameter int STAGES = gte_pkg::DEF_CORDIC_STAGES
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [gte_pkg::ANG_W-1:0] angle_i,
  output logic signed [gte_pkg::TRIG_W-1:0] cos_o,
  output logic signed [gte_pkg::TRIG_W-1:0] sin_o
);
  import gte_pkg::*;

  localparam int NST = (STAGES > MAX_STAGES) ? MAX_STAGES : STAGES;

  logic signed [CW-1:0] x_r [NST];
  logic signed [CW-1:0] y_r [NST];
  logic signed [ZW-1:0] z_r [NST];

  for (genvar g = 0; g < NST; g++) begin : gen_stage
    logic signed [CW-1:0] xi;
    logic signed [CW-1:0] yi;
    logic signed [ZW-1:0] zi;
    logic signed [ZW-1:0] at;

    if (g == 0) begin : gen_first
      assign xi = GAIN_Q30;
      assign yi = '0;
      assign zi = ZW'(angle_i);
    end else begin : gen_next
      assign xi = x_r[g-1];
      assign yi = y_r[g-1];
      assign zi = z_r[g-1];
    end

    assign at = $signed({3'b000, atan_q30(g)});

    always_ff @(posedge clk) begin
      if (en) begin
        if (!zi[ZW-1]) begin
          x_r[g] <= xi - (yi >>> g);
          y_r[g] <= yi + (xi >>> g);
          z_r[g] <= zi - at;
        end else begin
          x_r[g] <= xi + (yi >>> g);
          y_r[g] <= yi - (xi >>> g);
          z_r[g] <= zi + at;
        end
      end
    end
  end

  always_comb begin
    if (x_r[NST-1] > Q_ONE) cos_o = TRIG_W'(Q_ONE);
    else if (x_r[NST-1] < -Q_ONE) cos_o = TRIG_W'(-Q_ONE);
    else cos_o = TRIG_W'(x_r[NST-1]);
    if (y_r[NST-1] > Q_ONE) sin_o = TRIG_W'(Q_ONE);
    else if (y_r[NST-1] < -Q_ONE) sin_o = TRIG_W'(-Q_ONE);
    else sin_o = TRIG_W'(y_r[NST-1]);
  end

endmodule

FILE: hdl/gte_nrad.sv
// Prime-vertical radius: pipelined square root then pipelined divide.
module gte_nrad (
  input  logic                        clk,
  input  logic                        en,
  input  logic [gte_pkg::D_W-1:0]     d_i,
  output logic [gte_pkg::NQ_W-1:0]    n_o
);
  import gte_pkg::*;

  logic [60:0]       sq_rem_r  [SQ_STEPS];
  logic [ROOT_W-1:0] sq_root_r [SQ_STEPS];

  for (genvar j = 0; j < SQ_STEPS; j++) begin : gen_sqrt
    localparam int B = SQ_STEPS - 1 - j;
    logic [60:0]       rem_i;
    logic [ROOT_W-1:0] root_i;
    logic [62:0]       trial;

    if (j == 0) begin : gen_first
      assign rem_i  = {d_i, 20'b0};
      assign root_i = '0;
    end else begin : gen_next
      assign rem_i  = sq_rem_r[j-1];
      assign root_i = sq_root_r[j-1];
    end

    assign trial = (63'(root_i) << (B + 1)) + (63'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if (63'(rem_i) >= trial) begin
          sq_rem_r[j]  <= 61'(63'(rem_i) - trial);
          sq_root_r[j] <= root_i | (ROOT_W'(1) << B);
        end else begin
          sq_rem_r[j]  <= rem_i;
          sq_root_r[j] <= root_i;
        end
      end
    end
  end

  logic [ROOT_W-1:0] rt;
  assign rt = (sq_root_r[SQ_STEPS-1] == '0) ? ROOT_W'(1) : sq_root_r[SQ_STEPS-1];

  logic [63:0]       dv_rem_r [DIV_STEPS];
  logic [NQ_W-1:0]   dv_q_r   [DIV_STEPS];
  logic [ROOT_W-1:0] dv_d_r   [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : gen_div
    localparam int B = DIV_STEPS - 1 - j;
    logic [63:0]       rem_i;
    logic [NQ_W-1:0]   q_i;
    logic [ROOT_W-1:0] d_s;
    logic [64:0]       sub;

    if (j == 0) begin : gen_first
      // numerator a*2^30 plus half the divisor for round half up
      assign rem_i = SEMI_Q30 + 64'(rt >> 1);
      assign q_i   = '0;
      assign d_s   = rt;
    end else begin : gen_next
      assign rem_i = dv_rem_r[j-1];
      assign q_i   = dv_q_r[j-1];
      assign d_s   = dv_d_r[j-1];
    end

    assign sub = 65'(d_s) << B;

    always_ff @(posedge clk) begin
      if (en) begin
        dv_d_r[j] <= d_s;
        if (65'(rem_i) >= sub) begin
          dv_rem_r[j] <= 64'(65'(rem_i) - sub);
          dv_q_r[j]   <= q_i | (NQ_W'(1) << B);
        end else begin
          dv_rem_r[j] <= rem_i;
          dv_q_r[j]   <= q_i;
        end
      end
    end
  end

  assign n_o = dv_q_r[DIV_STEPS-1];

endmodule
